// ----- sv/tli_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tli_pkg: shared types and constants
// Widths, status and operation codes and the saturation helper used by the
// table interpolator and its divider.
// ---------------------------------------------------------------------------
package tli_pkg;

    localparam int DW         = 32;   // Q16.16 sample width
    localparam int DEPTH      = 64;   // table entries
    localparam int AW         = 6;    // table address width
    localparam int CW         = 7;    // point count register width
    localparam int FRAC_BITS  = 16;
    localparam int CNT_MIN    = 3;
    localparam int CNT_MAX    = 64;

    typedef logic signed [DW-1:0] t_data;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_DUP   = 2'd2;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // clamp a 64-bit signed value to the signed 32-bit range
    function automatic t_data f_sat(input logic signed [63:0] v);
        t_data r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/table_lagrange_interpolator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// table_lagrange_interpolator_core: table Lagrange interpolator
// Loads (x, y) points into a RAM and answers Q16.16 interpolation queries
// through a 3- or 4-point local Lagrange polynomial.
// ---------------------------------------------------------------------------
// Load: accepted even while a result waits on the output.
// Query: reads the table ends, searches the intervals one by one (up to n - 1),
//   loads the 3 or 4 chosen points, checks them for duplicate abscissas, then
//   per ratio runs the serial divider, multiplies and scales, and adds each
//   point's term to the sum; an out-of-range query stops after the end check.
// Reset (synchronous, active low) clears control and sets point count to 3;
// table contents are undefined until loaded.
// ---------------------------------------------------------------------------
module table_lagrange_interpolator_core
    import tli_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [6:0]  i_cfg_wdata,    // point_count
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,   // point_index[5:0], x_value, y_value, zero pad
    input  wire logic [0:0]  s_axis_tuser,   // operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // interpolated_y
    output logic [1:0]       m_axis_tuser    // status
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIRST = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_SRCH  = 4'd3;
    localparam logic [3:0] S_LD    = 4'd4;
    localparam logic [3:0] S_DUP   = 4'd5;
    localparam logic [3:0] S_NEXT  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_SCL   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]    r_state;
    logic [CW-1:0] r_n;
    t_data         r_x, r_first, r_prev, r_xk, r_term, r_ratio, r_res;
    logic [1:0]    r_rst;
    logic [AW-1:0] r_i, r_start;
    logic [2:0]    r_cnt, r_ld, r_j, r_k;
    t_data         r_px [4];
    t_data         r_py [4];
    logic signed [33:0] r_sum;
    logic signed [63:0] r_prod;
    logic          r_mvalid;
    t_data         r_mdata;
    logic [1:0]    r_mst;

    // input fields
    logic          in_op;
    logic [AW-1:0] in_idx;
    t_data         in_x, in_y;
    logic          in_acc;
    assign in_op  = s_axis_tuser[0];
    assign in_idx = s_axis_tdata[5:0];
    assign in_x   = s_axis_tdata[37:6];
    assign in_y   = s_axis_tdata[69:38];
    assign s_axis_tready = r_state == S_IDLE;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // table RAM: {y, x}
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [63:0]   ram_rdata;
    t_data         rd_x, rd_y;
    assign rd_x = ram_rdata[31:0];
    assign rd_y = ram_rdata[63:32];
    assign ram_we = in_acc && in_op == OP_LOAD;

    logic [CW-1:0] n_m1, n_m2;
    assign n_m1 = r_n - 7'd1;
    assign n_m2 = r_n - 7'd2;

    always_comb begin
        unique case (r_state)
            S_IDLE:  ram_addr = ram_we ? in_idx : '0;
            S_FIRST: ram_addr = n_m1[AW-1:0];
            S_CHK:   ram_addr = AW'(1);
            S_SRCH:  ram_addr = r_i + AW'(2);
            S_LD:    ram_addr = r_start + AW'(r_ld);
            default: ram_addr = '0;
        endcase
    end

    tli_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata ({in_y, in_x}),
        .o_rdata (ram_rdata)
    );

    // range and interval tests
    logic out_rng, hit, last_iv, f_first, f_last;
    always_comb begin
        if (r_first < rd_x) begin
            out_rng = r_x < r_first || r_x > rd_x;
        end else begin
            out_rng = r_x > r_first || r_x < rd_x;
        end
        hit = (r_x < r_prev && r_x >= rd_x) || (r_x > r_prev && r_x <= rd_x)
            || (r_i == '0 && r_x == r_prev);
        last_iv = {1'b0, r_i} == n_m2;
        f_first = r_i == '0;
        f_last  = last_iv;
    end

    // duplicate abscissa check over the chosen points
    logic dup;
    always_comb begin
        dup = 1'b0;
        for (int a = 0; a < 4; a++) begin
            for (int b = a + 1; b < 4; b++) begin
                if (3'(b) < r_cnt && r_px[a] == r_px[b]) begin
                    dup = 1'b1;
                end
            end
        end
    end

    // one read port into the point registers
    logic [2:0] rd_idx;
    t_data      px_rd, py_rd;
    assign rd_idx = (r_j == r_cnt) ? r_k + 3'd1 : r_j;
    assign px_rd  = r_px[rd_idx[1:0]];
    assign py_rd  = r_py[rd_idx[1:0]];

    // divider
    logic  div_start, div_busy, div_done;
    t_data div_ratio;
    assign div_start = r_state == S_NEXT && r_j != r_cnt && r_j != r_k;

    tli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (33'(r_x) - 33'(px_rd)),
        .i_den   (33'(r_xk) - 33'(px_rd)),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_ratio (div_ratio)
    );

    // scaling and accumulation
    logic signed [63:0] prod_adj;
    logic signed [33:0] sum_new;
    assign prod_adj = (r_prod + (r_prod[63] ? 64'sd65535 : 64'sd0)) >>> FRAC_BITS;
    assign sum_new  = r_sum + 34'(r_term);

    logic slot_free;
    assign slot_free = !r_mvalid || m_axis_tready;

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_n      <= 7'(CNT_MIN);
            r_mvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_wdata < 7'(CNT_MIN)) begin
                    r_n <= 7'(CNT_MIN);
                end else if (i_cfg_wdata > 7'(CNT_MAX)) begin
                    r_n <= 7'(CNT_MAX);
                end else begin
                    r_n <= i_cfg_wdata;
                end
            end
            // output slot: a new result wins over the drain
            if (r_state == S_OUT && slot_free) begin
                r_mvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && in_op == OP_QUERY) begin
                        r_state <= S_FIRST;
                    end
                end
                S_FIRST: r_state <= S_CHK;
                S_CHK: begin
                    r_state <= out_rng ? S_OUT : S_SRCH;
                end
                S_SRCH: begin
                    if (hit || last_iv) begin
                        r_state <= hit ? S_LD : S_OUT;
                    end
                end
                S_LD: begin
                    if (r_ld == r_cnt) begin
                        r_state <= S_DUP;
                    end
                end
                S_DUP: r_state <= dup ? S_OUT : S_NEXT;
                S_NEXT: begin
                    if (r_j == r_cnt && r_k + 3'd1 == r_cnt) begin
                        r_state <= S_OUT;
                    end else if (div_start) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_SCL;
                S_SCL: r_state <= S_NEXT;
                S_OUT: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_x <= in_x;
            end
            S_FIRST: r_first <= rd_x;
            S_CHK: begin
                r_res  <= '0;
                r_rst  <= out_rng ? ST_RANGE : ST_OK;
                r_prev <= r_first;
                r_i    <= '0;
            end
            S_SRCH: begin
                r_start <= f_first ? '0 : r_i - AW'(1);
                r_cnt   <= (f_first || f_last) ? 3'd3 : 3'd4;
                r_ld    <= '0;
                r_prev  <= rd_x;
                r_i     <= r_i + AW'(1);
            end
            S_LD: begin
                if (r_ld != '0) begin
                    r_px[2'(r_ld - 3'd1)] <= rd_x;
                    r_py[2'(r_ld - 3'd1)] <= rd_y;
                end
                r_ld <= r_ld + 3'd1;
            end
            S_DUP: begin
                r_res  <= 32'sh7FFFFFFF;
                r_rst  <= ST_DUP;
                r_xk   <= r_px[0];
                r_term <= r_py[0];
                r_k    <= '0;
                r_j    <= '0;
                r_sum  <= '0;
            end
            S_NEXT: begin
                if (r_j == r_cnt) begin
                    r_sum  <= sum_new;
                    r_res  <= f_sat(64'(sum_new));
                    r_rst  <= ST_OK;
                    r_k    <= r_k + 3'd1;
                    r_j    <= '0;
                    r_xk   <= px_rd;
                    r_term <= py_rd;
                end else if (r_j == r_k) begin
                    r_j <= r_j + 3'd1;
                end
            end
            S_DIV: r_ratio <= div_ratio;
            S_MUL: r_prod  <= 64'(r_term) * 64'(r_ratio);
            S_SCL: begin
                r_term <= f_sat(prod_adj);
                r_j    <= r_j + 3'd1;
            end
            S_OUT: begin
                if (slot_free) begin
                    r_mdata <= r_res;
                    r_mst   <= r_rst;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tuser  = r_mst;

    // checks
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy) else $error("divider started while busy");
    a_out_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && slot_free) |=> r_mvalid) else $error("result lost");
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mvalid && r_mst == ST_RANGE) |-> r_mdata == '0)
        else $error("out-of-range result not zero");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mvalid |-> (r_mst == ST_OK || r_mst == ST_RANGE || r_mst == ST_DUP))
        else $error("bad status code");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !s_axis_tready) else $error("input taken mid query");

endmodule
`default_nettype wire

// ----- sv/tli_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tli_ram: generic single-port RAM
// One address per cycle, written and read together; read data registered.
// ---------------------------------------------------------------------------
module tli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

// ----- sv/tli_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tli_div: serial Q16.16 ratio divider
// Computes sat((num << 16) / den), truncated toward zero, one quotient bit
// per cycle by restoring division on the magnitudes.
// ---------------------------------------------------------------------------
module tli_div
    import tli_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [32:0] i_num,
    input  wire logic signed [32:0] i_den,
    output logic                    o_busy,
    output logic                    o_done,
    output t_data                   o_ratio
);

    localparam int QW = 33 + FRAC_BITS;   // dividend magnitude bits

    logic [QW-1:0] r_quo;
    logic [32:0]   r_rem;
    logic [32:0]   r_den;
    logic          r_neg;
    logic [5:0]    r_cnt;
    logic          r_done;

    logic [32:0]   num_mag;
    logic [32:0]   den_mag;
    logic [33:0]   shifted;
    logic          take;
    logic signed [63:0] q_signed;

    assign num_mag = i_num[32] ? 33'(-i_num) : 33'(i_num);
    assign den_mag = i_den[32] ? 33'(-i_den) : 33'(i_den);

    // one restoring step
    assign shifted = {r_rem, r_quo[QW-1]};
    assign take    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && r_cnt == '0) begin
                r_cnt <= 6'(QW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start && r_cnt == '0) begin
            r_quo <= {num_mag, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_den <= den_mag;
            r_neg <= i_num[32] ^ i_den[32];
        end else if (r_cnt != '0) begin
            r_rem <= take ? 33'(shifted - {1'b0, r_den}) : shifted[32:0];
            r_quo <= {r_quo[QW-2:0], take};
        end
    end

    assign q_signed = r_neg ? -$signed({15'd0, r_quo}) : $signed({15'd0, r_quo});
    assign o_ratio  = f_sat(q_signed);
    assign o_busy   = r_cnt != '0;
    assign o_done   = r_done;

endmodule
`default_nettype wire

// ----- tb/table_lagrange_interpolator_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// table_lagrange_interpolator_checker: scoreboard for the table interpolator
// Watches the config port and both streams, keeps a private copy of the
// point table, computes the expected interpolated value and status of every
// query and compares each result transaction with the oldest expectation.
// ---------------------------------------------------------------------------
module table_lagrange_interpolator_checker
    import tli_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [6:0]  i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [71:0] i_s_tdata,
    input  wire logic [0:0]  i_s_tuser,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [31:0] i_m_tdata,
    input  wire logic [1:0]  i_m_tuser,
    output int               o_errors,
    output int               o_pending
);

    typedef struct packed {
        logic [31:0] y;
        logic [1:0]  st;
    } t_interp;

    longint      pts_x [DEPTH];
    longint      pts_y [DEPTH];
    logic [6:0]  npts_reg;
    t_interp     expected_q[$];

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    function automatic longint clamp32(input longint v);
        longint r;
        r = (v > SAT_HI) ? SAT_HI : (v < SAT_LO) ? SAT_LO : v;
        return r;
    endfunction

    // local Lagrange evaluation over the private table copy
    function automatic t_interp interpolate(input longint xq);
        t_interp res;
        int      n, found, start, cnt;
        longint  first, last, a, b, sum, term, num, den, ratio;
        res.y  = '0;
        res.st = ST_OK;
        n = npts_reg;
        if (n < CNT_MIN) n = CNT_MIN;
        if (n > CNT_MAX) n = CNT_MAX;
        first = pts_x[0];
        last  = pts_x[n-1];
        if ((first < last) ? (xq < first || xq > last) : (xq > first || xq < last)) begin
            res.st = ST_RANGE;
            return res;
        end
        found = -1;
        for (int i = 0; i < n - 1; i++) begin
            a = pts_x[i];
            b = pts_x[i+1];
            if ((xq < a && xq >= b) || (xq > a && xq <= b) || (i == 0 && xq == a)) begin
                found = i;
                break;
            end
        end
        if (found < 0) return res;
        if (found == 0) begin
            start = 0; cnt = 3;
        end else if (found == n - 2) begin
            start = found - 1; cnt = 3;
        end else begin
            start = found - 1; cnt = 4;
        end
        // duplicate abscissas saturate to positive full scale
        for (int k = start; k < start + cnt; k++)
            for (int j = start; j < start + cnt; j++)
                if (j != k && pts_x[k] == pts_x[j]) begin
                    res.y  = 32'h7FFFFFFF;
                    res.st = ST_DUP;
                    return res;
                end
        sum = 0;
        for (int k = start; k < start + cnt; k++) begin
            term = pts_y[k];
            for (int j = start; j < start + cnt; j++) begin
                if (j == k) continue;
                num   = xq - pts_x[j];
                den   = pts_x[k] - pts_x[j];
                ratio = clamp32((num * 65536) / den);
                term  = clamp32((term * ratio) / 65536);
            end
            sum += term;
        end
        res.y = 32'(clamp32(sum));
        return res;
    endfunction

    // sample all channels at the rising edge
    always @(posedge i_clk) begin
        t_interp exp_r;
        if (!i_rst_n) begin
            npts_reg <= 7'd3;
            expected_q.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) npts_reg <= i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0] == OP_LOAD) begin
                    pts_x[i_s_tdata[5:0]] = longint'($signed(i_s_tdata[37:6]));
                    pts_y[i_s_tdata[5:0]] = longint'($signed(i_s_tdata[69:38]));
                end else begin
                    expected_q.push_back(interpolate(longint'($signed(i_s_tdata[37:6]))));
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result y=%h status=%0d",
                             $time, i_m_tdata, i_m_tuser);
                    o_errors++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (exp_r.y !== i_m_tdata) begin
                        $display("%0t: y mismatch expected %h actual %h",
                                 $time, exp_r.y, i_m_tdata);
                        o_errors++;
                    end
                    if (exp_r.st !== i_m_tuser) begin
                        $display("%0t: status mismatch expected %0d actual %0d",
                                 $time, exp_r.st, i_m_tuser);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ----- tb/table_lagrange_interpolator_core_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// table_lagrange_interpolator_core_tb: stimulus and verdict
// Loads monotonic, duplicate, full-range and noise tables under many point counts,
// fires queries inside, at and outside the table with random idling and
// back-pressure; the checker module predicts and compares every result.
// ---------------------------------------------------------------------------
module table_lagrange_interpolator_core_tb;
    import tli_pkg::*;

    localparam longint CYCLE_LIMIT = 4000000;
    localparam int     HOLD_CYCLES = 3000;
    localparam int     ITEM_GOAL   = 1170;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    int          errors;
    int          pending;

    // stimulus-side copy of the table, only used to aim queries
    longint      tab_x [DEPTH];
    int          items;
    bit          quiet;
    bit          hold_req;
    bit          hold_done;
    longint      cycles;

    table_lagrange_interpolator_core uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    table_lagrange_interpolator_checker chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // cycle limit
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // result side: random back-pressure plus one long hold-off
    initial begin
        m_tready  = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end else begin
                m_tready <= quiet || ($urandom_range(0, 99) >= 19);
            end
        end
    end

    // one transaction on the input stream; called and returns at a falling edge
    task automatic send_item(input logic op, input logic [5:0] idx,
                             input logic [31:0] xv, input logic [31:0] yv);
        if (!quiet && $urandom_range(0, 99) < 19) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, yv, xv, idx};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        items++;
        if (op == OP_LOAD) tab_x[idx] = longint'($signed(xv));
    endtask

    // drain all results, let the block settle, then write point_count
    task automatic set_count(input logic [6:0] value);
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic int eff_count(input logic [6:0] value);
        int n;
        n = value;
        if (n < CNT_MIN) n = CNT_MIN;
        if (n > CNT_MAX) n = CNT_MAX;
        return n;
    endfunction

    function automatic longint rand_span(input longint span);
        longint r;
        r = longint'({1'b0, $urandom, $urandom} >> 2) % span;
        return r;
    endfunction

    // kinds of table
    typedef enum int {TB_INC, TB_DEC, TB_DUP, TB_FULL, TB_NOISE} t_tab_kind;

    task automatic load_table(input int n, input t_tab_kind kind);
        longint xs [DEPTH];
        longint step_max, base, yv;
        int     d;
        step_max = ($urandom_range(0, 3) == 0) ? 64'd67000000 : 64'd200000;
        base = -64'sd2147483648 + rand_span(64'sd4294967295 - step_max * DEPTH);
        xs[0] = base;
        for (int i = 1; i < n; i++) xs[i] = xs[i-1] + 1 + rand_span(step_max);
        if (kind == TB_FULL) begin
            xs[0]   = -64'sd2147483648;
            xs[n-1] = 64'sd2147483647;
        end
        if (kind == TB_DUP) begin
            d = $urandom_range(1, n - 1);
            xs[d] = xs[d-1];
        end
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0:       yv = longint'($signed($urandom));
                1:       yv = ($urandom_range(0, 1)) ? 64'sd2147483647 : -64'sd2147483648;
                default: yv = longint'($signed($urandom)) >>> 8;
            endcase
            if (kind == TB_NOISE)
                send_item(OP_LOAD, i[5:0], $urandom, yv[31:0]);
            else if (kind == TB_DEC)
                send_item(OP_LOAD, i[5:0], xs[n-1-i][31:0], yv[31:0]);
            else
                send_item(OP_LOAD, i[5:0], xs[i][31:0], yv[31:0]);
        end
    endtask

    // query aimed at the current table
    task automatic send_query(input int n);
        longint lo, hi, a, b, xq;
        int     i, r;
        lo = (tab_x[0] < tab_x[n-1]) ? tab_x[0] : tab_x[n-1];
        hi = (tab_x[0] < tab_x[n-1]) ? tab_x[n-1] : tab_x[0];
        r  = $urandom_range(0, 99);
        i  = $urandom_range(0, n - 2);
        a  = (tab_x[i] < tab_x[i+1]) ? tab_x[i] : tab_x[i+1];
        b  = (tab_x[i] < tab_x[i+1]) ? tab_x[i+1] : tab_x[i];
        if (r < 8) begin
            xq = longint'($signed($urandom));
        end else if (r < 18) begin
            if (lo > -64'sd2147483648 && (hi == 64'sd2147483647 || $urandom_range(0, 1)))
                xq = lo - 1 - rand_span(lo + 64'sd2147483648 < 1000 ?
                                        lo + 64'sd2147483648 : 1000);
            else if (hi < 64'sd2147483647)
                xq = hi + 1 + rand_span(64'sd2147483647 - hi < 1000 ?
                                        64'sd2147483647 - hi : 1000);
            else
                xq = lo;
        end else if (r < 32) begin
            xq = tab_x[$urandom_range(0, n - 1)];
        end else begin
            xq = a + rand_span(b - a + 1);
        end
        send_item(OP_QUERY, $urandom, xq[31:0], $urandom);
    endtask

    initial begin
        int        n;
        logic [6:0] cv;
        t_tab_kind kind;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_LOAD;
        items     = 0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // directed: write every entry once over the full signed range
        load_table(DEPTH, TB_FULL);
        set_count(7'd64);
        send_item(OP_QUERY, 6'd0, 32'h80000000, 32'h0);      // first point
        send_item(OP_QUERY, 6'd63, 32'h7FFFFFFF, 32'hFFFFFFFF); // last point
        send_query(DEPTH);
        send_query(DEPTH);
        // three-point table, reset count: ends, outside, duplicates
        set_count(7'd0);
        send_item(OP_LOAD, 6'd0, 32'h00010000, 32'h7FFFFFFF);
        send_item(OP_LOAD, 6'd1, 32'h00020000, 32'h80000000);
        send_item(OP_LOAD, 6'd2, 32'h00030000, 32'h00050000);
        send_item(OP_QUERY, 6'd0, 32'h00010000, 32'h0);
        send_item(OP_QUERY, 6'd0, 32'h00018000, 32'h0);
        send_item(OP_QUERY, 6'd0, 32'h00030000, 32'h0);
        send_item(OP_QUERY, 6'd0, 32'h0000FFFF, 32'h0);
        send_item(OP_QUERY, 6'd0, 32'h00030001, 32'h0);
        send_item(OP_QUERY, 6'd0, 32'h80000000, 32'h0);
        send_item(OP_LOAD, 6'd1, 32'h00010000, 32'h0);       // duplicate x
        send_item(OP_QUERY, 6'd0, 32'h00020000, 32'h0);
        // decreasing table, out-of-range count
        set_count(7'd127);
        load_table(DEPTH, TB_DEC);
        send_query(DEPTH);
        send_query(DEPTH);

        // long receiver hold-off while queries keep coming
        set_count(7'd5);
        load_table(5, TB_INC);
        hold_req = 1'b1;
        repeat (6) send_query(5);
        while (!hold_done) @(negedge clk);

        // random phases
        while (items < ITEM_GOAL) begin
            case ($urandom_range(0, 9))
                0:       cv = $urandom_range(0, 2);
                1:       cv = $urandom_range(65, 127);
                2:       cv = $urandom_range(9, 64);
                default: cv = $urandom_range(3, 8);
            endcase
            quiet = ($urandom_range(0, 7) == 0);
            set_count(cv);
            n = eff_count(cv);
            case ($urandom_range(0, 9))
                0, 1, 2: kind = TB_INC;
                3, 4, 5: kind = TB_DEC;
                6:       kind = TB_DUP;
                7:       kind = TB_FULL;
                8:       kind = TB_NOISE;
                default: kind = TB_INC;
            endcase
            load_table(n, kind);
            repeat ($urandom_range(6, 14)) begin
                if ($urandom_range(0, 19) == 0)
                    send_item(OP_LOAD, $urandom_range(0, n - 1), $urandom, $urandom);
                else
                    send_query(n);
            end
        end
        quiet = 1'b0;

        // drain and settle
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
